/* hw/rtl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module in hw/rtl.
package uer_pkg;

	localparam int COUNT_BITS = 16;
	localparam int TICK_BITS  = 16;
	localparam int DIST_BITS  = 24;
	localparam int PROD_BITS  = COUNT_BITS + 8;
	localparam int ACC_BITS   = (PROD_BITS > DIST_BITS) ? PROD_BITS : DIST_BITS;
	localparam int LIM_BITS   = 17;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [ACC_BITS-1:0]   DIST_MAX  = ACC_BITS'({DIST_BITS{1'b1}});

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TRIGGER_TICKS = 3'd0,
		REG_SETTLE_TICKS  = 3'd1,
		REG_ECHO_WAIT     = 3'd2,
		REG_SCALE         = 3'd3,
		REG_MIN_DIST      = 3'd4,
		REG_MAX_DIST      = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOECHO = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

	// Limits are kept premultiplied by 100 (centimetres to hundredths)
	typedef struct packed {
		logic [7:0]          trigger_ticks;
		logic [15:0]         settle_ticks;
		logic [7:0]          echo_wait_limit;
		logic [7:0]          scale;
		logic [LIM_BITS-1:0] lo_lim;
		logic [LIM_BITS-1:0] hi_lim;
	} cfg_t;

	typedef struct packed {
		logic                 trigger;
		logic                 light;
		logic                 busy;
		logic                 done;
		status_t              status;
		logic [DIST_BITS-1:0] distance;
	} res_t;

	function automatic logic [LIM_BITS-1:0] cm_to_hundredths(input logic [9:0] cm);
		// x*100 = x*64 + x*32 + x*4
		return (LIM_BITS'(cm) << 6) + (LIM_BITS'(cm) << 5) + (LIM_BITS'(cm) << 2);
	endfunction

endpackage

/* hw/rtl/uer_cfg_regs.sv */
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for the register index codes and the cfg_t bundle.
module uer_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output uer_pkg::cfg_t                      cfg
);
	import uer_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks   <= 8'd2;
			cfg_q.settle_ticks    <= 16'd200;
			cfg_q.echo_wait_limit <= 8'd30;
			cfg_q.scale           <= 8'd17;
			cfg_q.lo_lim          <= cm_to_hundredths(10'd2);
			cfg_q.hi_lim          <= cm_to_hundredths(10'd400);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TRIGGER_TICKS: cfg_q.trigger_ticks   <= wr_data[7:0];
				REG_SETTLE_TICKS:  cfg_q.settle_ticks    <= wr_data[15:0];
				REG_ECHO_WAIT:     cfg_q.echo_wait_limit <= wr_data[7:0];
				REG_SCALE:         cfg_q.scale           <= wr_data[7:0];
				REG_MIN_DIST:      cfg_q.lo_lim          <= cm_to_hundredths(wr_data[9:0]);
				REG_MAX_DIST:      cfg_q.hi_lim          <= cm_to_hundredths(wr_data[9:0]);
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/uer_core.sv */
// Ranging sequencer: phase machine, tick and pulse counters, distance accumulator.
// Depends on uer_pkg; advances one step per accepted sample tick.
module uer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          start_req,
	input  logic          echo,
	input  uer_pkg::cfg_t cfg,
	output uer_pkg::res_t res
);
	import uer_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_TRIG   = 3'd1,
		PH_SETTLE = 3'd2,
		PH_WAIT   = 3'd3,
		PH_HIGH   = 3'd4
	} phase_t;

	phase_t                 phase_q,  phase_d;
	logic [TICK_BITS-1:0]   tick_q,   tick_d;
	logic [COUNT_BITS-1:0]  pulse_q,  pulse_d;
	logic [ACC_BITS-1:0]    acc_q,    acc_d;
	logic                   light_q,  light_d;
	status_t                status_q, status_d;
	logic [DIST_BITS-1:0]   dist_q,   dist_d;

	phase_t               ph;
	logic [TICK_BITS-1:0] tick_cur;
	logic [TICK_BITS-1:0] tick_inc;
	logic                 trig;
	logic                 done;
	logic                 finish;
	logic                 sat;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		pulse_d  = pulse_q;
		acc_d    = acc_q;
		light_d  = light_q;
		status_d = status_q;
		dist_d   = dist_q;
		trig     = 1'b0;
		done     = 1'b0;
		finish   = 1'b0;
		sat      = 1'b0;

		ph       = phase_q;
		tick_cur = tick_q;
		// A start taken while idle clears the light and becomes the first trigger tick
		if (phase_q == PH_IDLE && start_req) begin
			light_d  = 1'b0;
			ph       = PH_TRIG;
			tick_cur = '0;
		end
		tick_inc = tick_cur + TICK_BITS'(1);
		phase_d  = ph;
		tick_d   = tick_cur;

		case (ph)
			PH_TRIG: begin
				trig = 1'b1;
				if (tick_inc >= TICK_BITS'(cfg.trigger_ticks)) begin
					tick_d  = '0;
					phase_d = (cfg.settle_ticks == 16'd0) ? PH_WAIT : PH_SETTLE;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_SETTLE: begin
				if (tick_inc >= TICK_BITS'(cfg.settle_ticks)) begin
					tick_d  = '0;
					phase_d = PH_WAIT;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_WAIT: begin
				tick_d = tick_inc;
				if (tick_inc >= TICK_BITS'(cfg.echo_wait_limit)) begin
					status_d = ST_NOECHO;
					phase_d  = PH_IDLE;
					done     = 1'b1;
				end else if (echo) begin
					pulse_d = '0;
					acc_d   = '0;
					phase_d = PH_HIGH;
				end
			end
			PH_HIGH: begin
				// acc tracks pulse * scale, one add per counted tick
				if (pulse_q < COUNT_MAX) begin
					pulse_d = pulse_q + COUNT_BITS'(1);
					acc_d   = acc_q + ACC_BITS'(cfg.scale);
				end
				if (!echo) begin
					finish = 1'b1;
				end else if (pulse_d >= COUNT_MAX) begin
					finish = 1'b1;
					sat    = 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		if (finish) begin
			dist_d  = (acc_d > DIST_MAX) ? DIST_MAX[DIST_BITS-1:0] : acc_d[DIST_BITS-1:0];
			phase_d = PH_IDLE;
			done    = 1'b1;
			if (sat || acc_d > ACC_BITS'(cfg.hi_lim) || acc_d < ACC_BITS'(cfg.lo_lim)) begin
				status_d = ST_RANGE;
			end else begin
				status_d = ST_OK;
				light_d  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			pulse_q  <= '0;
			acc_q    <= '0;
			light_q  <= 1'b0;
			status_q <= ST_OK;
			dist_q   <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			pulse_q  <= pulse_d;
			acc_q    <= acc_d;
			light_q  <= light_d;
			status_q <= status_d;
			dist_q   <= dist_d;
		end
	end

	always_comb begin
		res.trigger  = trig;
		res.light    = light_d;
		res.busy     = (phase_d != PH_IDLE);
		res.done     = done;
		res.status   = status_d;
		res.distance = dist_d;
	end

endmodule

/* hw/rtl/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger: stream ports, config port, result register.
// Depends on uer_pkg, uer_cfg_regs and uer_core.
//
//  channel  | signals                                   | beat content
//  ---------+-------------------------------------------+-------------------------------
//  s (in)   | s_tvalid s_tready s_tdata[7:0]            | one sample tick: start, echo
//  m (out)  | m_tvalid m_tready m_tdata[31:0]           | pin levels and ranging status
//  cfg (in) | cfg_valid cfg_ready cfg_index cfg_data    | one register write
//
// Each input beat is processed combinationally and loads its result into the
// output register; one beat per cycle is sustained while m_tready is high.
// The output register is the only stall point: input is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset (arst_n low) returns the sequencer to idle, clears the counters, light,
// status and distance, and loads the default configuration.
// The config port is always ready; write only while no measurement is running.
module ultrasonic_echo_ranger (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample tick stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [0] start_req, [1] echo
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [31:0]                        m_tdata,   // [0] trigger, [1] light,
	                                                      // [2] busy_res, [3] done_res,
	                                                      // [5:4] status,
	                                                      // [29:6] distance_hundredths_cm
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import uer_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_vld_q;
	logic adv;

	// Take a new tick whenever the result register is free or draining
	assign s_tready  = !out_vld_q || m_tready;
	assign adv       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	uer_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	uer_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.start_req (s_tdata[0]),
		.echo      (s_tdata[1]),
		.cfg       (cfg),
		.res       (res)
	);

	// Valid flag of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, res_q.distance, res_q.status, res_q.done,
	                   res_q.busy, res_q.light, res_q.trigger};

`ifndef SYNTH
	// An accepted tick always leaves a result waiting
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("accepted tick produced no result");

	// A finishing tick is never still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.done && res_q.busy))
		else $error("done and busy set together");

	// Trigger is only driven inside a measurement
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.trigger) |-> res_q.busy)
		else $error("trigger driven while idle");

	// A finish that lights the indicator must be a success
	a_light_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.done && res_q.light) |-> (res_q.status == ST_OK))
		else $error("light set on failed measurement");
`endif

endmodule

/* tb/uer_checker.sv */
// Result checker for the ultrasonic echo ranger: follows the tick, result and config
// channels, predicts each result beat and compares it with the block's output.
// Depends on uer_pkg (register indexes, status codes, result layout, counter limit).
`timescale 1ns / 100ps

module uer_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [0] start_req, [1] echo
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [31:0]                       m_tdata,   // [0] trigger, [1] light, [2] busy,
	                                                     // [3] done, [5:4] status,
	                                                     // [29:6] distance
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output int                                mismatches,
	output int                                in_flight,
	output logic                              ranger_idle
);
	import uer_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_TRIG,
		SEQ_SETTLE,
		SEQ_WAIT,
		SEQ_HIGH
	} seq_step_t;

	// local copy of the configuration
	logic [7:0]  trig_ticks;
	logic [15:0] settle_ticks;
	logic [7:0]  poll_limit;
	logic [7:0]  scale;
	logic [9:0]  min_cm;
	logic [9:0]  max_cm;

	// sequencer state
	seq_step_t   step;
	logic [15:0] tick_cnt;
	logic [15:0] pulse_cnt;
	logic        light_on;
	status_t     held_status;
	logic [23:0] held_dist;

	res_t        expected_ticks[$];
	int          beat_no;

	function automatic res_t advance_ranger(input logic start, input logic echo);
		res_t        r;
		logic [31:0] span;
		logic [31:0] lo_lim;
		logic [31:0] hi_lim;
		logic        fin;
		logic        sat;
		r   = '0;
		fin = 1'b0;
		sat = 1'b0;
		if (step == SEQ_IDLE && start) begin
			light_on = 1'b0;
			step     = SEQ_TRIG;
			tick_cnt = '0;
		end
		case (step)
		SEQ_TRIG: begin
			r.trigger = 1'b1;
			tick_cnt  = tick_cnt + 16'd1;
			// zero trigger ticks still gives one trigger tick
			if (tick_cnt >= trig_ticks) begin
				tick_cnt = '0;
				step     = (settle_ticks == '0) ? SEQ_WAIT : SEQ_SETTLE;
			end
		end
		SEQ_SETTLE: begin
			tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= settle_ticks) begin
				tick_cnt = '0;
				step     = SEQ_WAIT;
			end
		end
		SEQ_WAIT: begin
			tick_cnt = tick_cnt + 16'd1;
			// the limit wins over an echo rising in the same tick
			if (tick_cnt >= poll_limit) begin
				held_status = ST_NOECHO;
				step        = SEQ_IDLE;
				r.done      = 1'b1;
			end else if (echo) begin
				pulse_cnt = '0;
				step      = SEQ_HIGH;
			end
		end
		SEQ_HIGH: begin
			if (pulse_cnt < COUNT_MAX)
				pulse_cnt = pulse_cnt + 16'd1;
			if (!echo) begin
				fin = 1'b1;
			end else if (pulse_cnt >= COUNT_MAX) begin
				fin = 1'b1;
				sat = 1'b1;
			end
		end
		default: step = SEQ_IDLE;
		endcase
		if (fin) begin
			span      = pulse_cnt * scale;
			lo_lim    = min_cm * 32'd100;
			hi_lim    = max_cm * 32'd100;
			held_dist = (span > 32'hFF_FFFF) ? 24'hFF_FFFF : span[23:0];
			if (sat || span > hi_lim || span < lo_lim) begin
				held_status = ST_RANGE;
			end else begin
				held_status = ST_OK;
				light_on    = 1'b1;
			end
			step   = SEQ_IDLE;
			r.done = 1'b1;
		end
		r.light    = light_on;
		r.busy     = (step != SEQ_IDLE);
		r.status   = held_status;
		r.distance = held_dist;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		res_t want;
		res_t got;
		if (!arst_n) begin
			trig_ticks   = 8'd2;
			settle_ticks = 16'd200;
			poll_limit   = 8'd30;
			scale        = 8'd17;
			min_cm       = 10'd2;
			max_cm       = 10'd400;
			step         = SEQ_IDLE;
			tick_cnt     = '0;
			pulse_cnt    = '0;
			light_on     = 1'b0;
			held_status  = ST_OK;
			held_dist    = '0;
			beat_no      = 0;
			mismatches   = 0;
			expected_ticks.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_TRIGGER_TICKS: trig_ticks   = cfg_data[7:0];
				REG_SETTLE_TICKS:  settle_ticks = cfg_data[15:0];
				REG_ECHO_WAIT:     poll_limit   = cfg_data[7:0];
				REG_SCALE:         scale        = cfg_data[7:0];
				REG_MIN_DIST:      min_cm       = cfg_data[9:0];
				REG_MAX_DIST:      max_cm       = cfg_data[9:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_ticks.push_back(advance_ranger(s_tdata[0], s_tdata[1]));
			if (m_tvalid && m_tready) begin
				got.trigger  = m_tdata[0];
				got.light    = m_tdata[1];
				got.busy     = m_tdata[2];
				got.done     = m_tdata[3];
				got.status   = status_t'(m_tdata[5:4]);
				got.distance = m_tdata[29:6];
				if (expected_ticks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat %0d arrived with nothing expected", beat_no);
				end else begin
					want = expected_ticks.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result beat %0d (expected/actual): trigger %b/%b ",
								"light %b/%b busy %b/%b done %b/%b status %0d/%0d ",
								"distance %0d/%0d"}, beat_no,
								want.trigger, got.trigger, want.light, got.light,
								want.busy, got.busy, want.done, got.done,
								want.status, got.status, want.distance, got.distance);
					end
				end
				beat_no++;
			end
		end
		in_flight   = expected_ticks.size();
		ranger_idle = (step == SEQ_IDLE);
	end

endmodule

/* tb/tb_ultrasonic_echo_ranger.sv */
// Testbench top for the ultrasonic echo ranger: clock, reset, tick and config stimulus,
// result back-pressure, watchdog and verdict. Depends on uer_pkg, uer_checker and the RTL.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger;
	import uer_pkg::*;

	// cycles without any accepted beat before the run is declared hung
	localparam int QUIET_LIMIT  = 2000;
	localparam int TOTAL_BEATS  = 450;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [7:0]               s_tdata;    // [0] start_req, [1] echo, [7:2] zero
	logic                     m_tvalid;
	logic                     m_tready;
	logic [31:0]              m_tdata;    // [0] trigger, [1] light, [2] busy_res,
	                                      // [3] done_res, [5:4] status,
	                                      // [29:6] distance_hundredths_cm
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int   mismatches;
	int   in_flight;
	logic ranger_idle;

	bit   fast_lane;        // set: neither side inserts idle cycles
	int   sent_beats;       // tick beats presented over the whole run
	int   quiet_cycles = 0;

	ultrasonic_echo_ranger DUT (.*);

	uer_checker ranger_check (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: any accepted beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: stall a random number of cycles before taking each beat.
	initial begin : drain_results
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = fast_lane ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Drop valid so that no stale beat is taken while the sender waits.
	task automatic hold_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Present one sample tick after a random gap and hold it until it is taken.
	task automatic send_tick(input logic start, input logic echo);
		int gap;
		gap = fast_lane ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, echo, start};
		sent_beats++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_ranger(input int trig, input int settle, input int poll,
			input int scl, input int lo_cm, input int hi_cm);
		write_reg(REG_TRIGGER_TICKS, CFG_DATA_BITS'(trig));
		write_reg(REG_SETTLE_TICKS, CFG_DATA_BITS'(settle));
		write_reg(REG_ECHO_WAIT, CFG_DATA_BITS'(poll));
		write_reg(REG_SCALE, CFG_DATA_BITS'(scl));
		write_reg(REG_MIN_DIST, CFG_DATA_BITS'(lo_cm));
		write_reg(REG_MAX_DIST, CFG_DATA_BITS'(hi_cm));
	endtask

	// One measurement: a start beat, then lead beats of low echo (the first junk of
	// them land in trigger/settle, where echo is ignored, so drive it at random),
	// pulse beats of high echo and tail beats of low echo. With nag set, sprinkle
	// start requests over the beats after the first.
	task automatic range_once(input int lead, input int junk, input int pulse,
			input int tail, input bit nag);
		int   i;
		logic poke;
		send_tick(1'b1, 1'b0);
		for (i = 0; i < lead + pulse + tail; i++) begin
			poke = nag && ($urandom_range(0, 3) == 0);
			if (i < junk) begin
				send_tick(poke, 1'($urandom_range(0, 1)));
			end else begin
				send_tick(poke, i >= lead && i < lead + pulse);
			end
		end
	endtask

	// Bring the block to idle: feed empty ticks until the sequencer is predicted idle,
	// then pause until every expected result has been returned.
	task automatic settle_block();
		hold_input();
		while (!ranger_idle) begin
			send_tick(1'b0, 1'b0);
			hold_input();
		end
		while (in_flight != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin : stimulus
		int trig;
		int settle;
		int poll;
		int scl;
		int lo_cm;
		int hi_cm;
		int lead0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_TRIGGER_TICKS;
		cfg_data   = '0;
		fast_lane  = 1'b1;
		sent_beats = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: trigger 2, settle 200, poll limit 30, scale 17, 2..400 cm.
		// Echo rises on the third poll tick.
		range_once(1 + 200 + 2, 1 + 200, 20, 1, 1'b0);
		settle_block();

		fast_lane = 1'b0;
		// shortest path: echo up on the first poll tick, starts while busy ignored
		set_ranger(1, 0, 3, 255, 0, 1023);
		range_once(0, 0, 1, 1, 1'b1);
		settle_block();
		// zero trigger ticks act as one; zero poll limit times out on the first poll,
		// even with echo high in that tick
		set_ranger(0, 1, 0, 17, 2, 400);
		range_once(1, 1, 1, 1, 1'b0);
		settle_block();
		// echo rises exactly when the poll count hits the limit: still a timeout
		set_ranger(1, 0, 2, 17, 2, 400);
		range_once(1, 0, 1, 1, 1'b0);
		settle_block();
		// distance equal to both limits passes
		set_ranger(1, 0, 5, 100, 2, 2);
		range_once(0, 0, 2, 1, 1'b0);
		settle_block();
		// minimum above maximum: nothing passes
		set_ranger(1, 0, 5, 1, 1023, 0);
		range_once(0, 0, 3, 1, 1'b0);
		settle_block();
		// zero scale gives zero distance
		set_ranger(2, 3, 4, 0, 0, 0);
		range_once(1 + 3, 1 + 3, 4, 1, 1'b0);
		settle_block();

		// Random phases: mostly well-formed measurements with short timing, random
		// pulse widths and limits; some noise bursts and stray starts in between.
		while (sent_beats < TOTAL_BEATS) begin
			trig   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
			settle = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
				: $urandom_range(0, 10);
			poll   = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 15);
			scl    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
			lo_cm  = $urandom_range(0, 30);
			hi_cm  = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 200);
			fast_lane = ($urandom_range(0, 3) == 0);
			set_ranger(trig, settle, poll, scl, lo_cm, hi_cm);
			lead0 = ((trig == 0) ? 1 : trig) - 1 + settle;
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6)) begin
						send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
					end
				end
				range_once(lead0 + $urandom_range(0, poll + 1), lead0,
					($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 24),
					$urandom_range(0, 3), 1'($urandom_range(0, 1)));
				// now and then stop sending until the block has caught up
				if ($urandom_range(0, 5) == 0)
					settle_block();
			end
			settle_block();
		end

		settle_block();
		if (mismatches == 0 && in_flight == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
